[design/assert_macros.svh]
// Assertion helpers used by weighted_edge_table.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/wet_pkg.sv]
package wet_pkg;

   localparam int MAX_VERTICES = 32;
   localparam int VERTEX_W     = $clog2(MAX_VERTICES);
   localparam int CELLS        = MAX_VERTICES * MAX_VERTICES;
   localparam int CELL_W       = $clog2(CELLS);
   localparam int WEIGHT_W     = 32;
   localparam int COUNT_W      = 10;
   localparam int VCOUNT_W     = 6;
   localparam int CSR_DATA_W   = 32;

   typedef enum logic [3:0] {
      ACT_REBUILD         = 4'd0,
      ACT_CONNECT_MIN     = 4'd1,
      ACT_CONNECT_DEFAULT = 4'd2,
      ACT_DISCONNECT      = 4'd3,
      ACT_SET             = 4'd4,
      ACT_SET_DEFAULT     = 4'd5,
      ACT_QUERY           = 4'd6,
      ACT_MIN_INCOMING    = 4'd7,
      ACT_REMOVE_INCOMING = 4'd8
   } action_type;

   typedef enum logic [1:0] {
      STAT_DONE    = 2'd0,
      STAT_RANGE   = 2'd1,
      STAT_MISSING = 2'd2
   } status_type;

   typedef enum logic {
      CSR_VERTEX_COUNT   = 1'b0,
      CSR_DEFAULT_WEIGHT = 1'b1
   } csr_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ACCESS,
      S_SCAN,
      S_REBUILD,
      S_REPLY
   } state_type;

   // One stored edge: presence flag and Q16.16 weight.
   typedef struct packed {
      logic                present;
      logic [WEIGHT_W-1:0] weight;
   } entry_type;

endpackage

[design/wet_ram.sv]
module wet_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold the last read word while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/weighted_edge_table.sv]
// Weighted directed edge store for up to 32 vertices, one entry per
// (source, destination) pair, held in a 1024-entry single-port-write RAM.
// Request channel (req_*): one action per transaction. Response channel
// (rsp_*): exactly one result per request, in order. Configuration (csr_*):
// index 0 vertex_count, index 1 the default weight; always ready. It is to
// be written by the user only while no request is in flight; the block
// itself does not enforce this.
// After acceptance, an edge action (connect, disconnect, set, query) reads
// its entry and rewrites it, where the action calls for it, in the access
// state; minimum incoming / remove incoming walk the column with one RAM
// read per source row; rebuild sweeps the table with one RAM write per
// entry; an out-of-range or reserved action goes straight to the reply.
// One request is worked on at a time; the next is taken the cycle after the
// result has moved into the response register.
// Reset: a clearing pass over all 1024 entries marks every entry absent;
// req_ready stays low until it ends. Configuration writes are taken during it.
// A stalled response holds its register; a finished result then waits in
// the block and no new request is taken until the register frees.
`include "assert_macros.svh"

module weighted_edge_table
   import wet_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [3:0]            req_action,
   input  logic [VERTEX_W-1:0]   req_source,
   input  logic [VERTEX_W-1:0]   req_destination,
   input  logic signed [WEIGHT_W-1:0] req_weight,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic                  rsp_found,
   output logic [VERTEX_W-1:0]   rsp_min_source,
   output logic signed [WEIGHT_W-1:0] rsp_min_weight,
   output logic [COUNT_W-1:0]    rsp_edge_count,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam logic [VCOUNT_W-1:0] MAX_N    = VCOUNT_W'(MAX_VERTICES);
   localparam logic [VERTEX_W-1:0] LAST_ROW = VERTEX_W'(MAX_VERTICES - 1);
   localparam logic [CELL_W-1:0]   LAST_CELL = CELL_W'(CELLS - 1);

   state_type state_ff, state_in;

   logic [VCOUNT_W-1:0] vertex_count_ff;
   logic [WEIGHT_W-1:0] base_weight_ff;

   action_type          op_ff, op_in;
   logic [VERTEX_W-1:0] src_ff, src_in;
   logic [VERTEX_W-1:0] dst_ff, dst_in;
   logic [WEIGHT_W-1:0] wt_ff, wt_in;
   logic [VERTEX_W-1:0] row_ff, row_in;
   logic [CELL_W-1:0]   sweep_ff, sweep_in;
   logic [COUNT_W-1:0]  count_ff, count_in;

   status_type          res_status_ff, res_status_in;
   logic                res_found_ff, res_found_in;
   logic [VERTEX_W-1:0] res_msrc_ff, res_msrc_in;
   logic [WEIGHT_W-1:0] res_mw_ff, res_mw_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff;
   logic                rsp_found_ff;
   logic [VERTEX_W-1:0] rsp_msrc_ff;
   logic [WEIGHT_W-1:0] rsp_mw_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   logic                req_accept;
   logic                rsp_load;
   action_type          req_act;
   logic [VCOUNT_W-1:0] n_active;
   logic                src_ok;
   logic                dst_ok;
   logic                range_fail;

   logic                mem_we;
   logic [CELL_W-1:0]   mem_waddr;
   entry_type           mem_wdata;
   logic                mem_re;
   logic [CELL_W-1:0]   mem_raddr;
   logic [$bits(entry_type)-1:0] mem_rdata;
   entry_type           cur;
   logic                new_lower;
   logic                scan_lower;
   logic                row_last;
   logic                sweep_last;
   logic [VERTEX_W-1:0] sweep_row;
   logic [VERTEX_W-1:0] sweep_col;
   logic                rb_present;

   wet_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (CELLS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // ---- decode ----
   assign req_act    = action_type'(req_action);
   assign req_accept = req_valid && req_ready;
   assign n_active   = (vertex_count_ff < MAX_N) ? vertex_count_ff : MAX_N;
   assign src_ok     = VCOUNT_W'(req_source) < n_active;
   assign dst_ok     = VCOUNT_W'(req_destination) < n_active;

   always_comb begin
      case (req_act)
         ACT_CONNECT_MIN, ACT_CONNECT_DEFAULT, ACT_DISCONNECT,
         ACT_SET, ACT_SET_DEFAULT, ACT_QUERY: range_fail = !(src_ok && dst_ok);
         ACT_MIN_INCOMING, ACT_REMOVE_INCOMING: range_fail = !dst_ok;
         default: range_fail = 1'b0;
      endcase
   end

   assign cur        = entry_type'(mem_rdata);
   assign new_lower  = $signed(wt_ff) < $signed(cur.weight);
   assign scan_lower = $signed(cur.weight) < $signed(res_mw_ff);
   assign row_last   = row_ff == LAST_ROW;
   assign sweep_last = sweep_ff == LAST_CELL;
   assign sweep_row  = sweep_ff[CELL_W-1:VERTEX_W];
   assign sweep_col  = sweep_ff[VERTEX_W-1:0];
   assign rb_present = (VCOUNT_W'(sweep_row) < n_active)
                       && (VCOUNT_W'(sweep_col) < n_active)
                       && (sweep_row != sweep_col);

   // ---- next state ----
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_accept) begin
               if (req_act == ACT_REBUILD) begin
                  state_in = S_REBUILD;
               end else if (range_fail) begin
                  state_in = S_REPLY;
               end else begin
                  case (req_act)
                     ACT_CONNECT_MIN, ACT_CONNECT_DEFAULT, ACT_DISCONNECT,
                     ACT_SET, ACT_SET_DEFAULT, ACT_QUERY: state_in = S_ACCESS;
                     ACT_MIN_INCOMING, ACT_REMOVE_INCOMING: state_in = S_SCAN;
                     default: state_in = S_REPLY;
                  endcase
               end
            end
         end
         S_ACCESS: state_in = S_REPLY;
         S_SCAN: begin
            if (row_last) state_in = S_REPLY;
         end
         S_REBUILD: begin
            if (sweep_last) state_in = S_REPLY;
         end
         S_REPLY: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // ---- FSM outputs: handshakes and RAM controls ----
   always_comb begin
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = {src_ff, dst_ff};
      mem_wdata = '{present: 1'b1, weight: wt_ff};
      mem_re    = 1'b0;
      mem_raddr = {req_source, req_destination};
      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = '{present: 1'b0, weight: base_weight_ff};
         end
         S_IDLE: begin
            req_ready = 1'b1;
            mem_re    = req_valid;
            // column actions start at source row zero
            if (req_act == ACT_MIN_INCOMING || req_act == ACT_REMOVE_INCOMING) begin
               mem_raddr = {VERTEX_W'(0), req_destination};
            end
         end
         S_ACCESS: begin
            case (op_ff)
               ACT_CONNECT_MIN: begin
                  mem_we = !cur.present || new_lower;
               end
               ACT_CONNECT_DEFAULT: begin
                  mem_we    = !cur.present;
                  mem_wdata = '{present: 1'b1, weight: base_weight_ff};
               end
               ACT_DISCONNECT: begin
                  mem_we    = cur.present;
                  mem_wdata = '{present: 1'b0, weight: cur.weight};
               end
               ACT_SET: begin
                  mem_we = cur.present;
               end
               ACT_SET_DEFAULT: begin
                  mem_we    = cur.present;
                  mem_wdata = '{present: 1'b1, weight: base_weight_ff};
               end
               default: mem_we = 1'b0;
            endcase
         end
         S_SCAN: begin
            mem_re    = !row_last;
            mem_raddr = {row_ff + VERTEX_W'(1), dst_ff};
            mem_we    = (op_ff == ACT_REMOVE_INCOMING) && cur.present;
            mem_waddr = {row_ff, dst_ff};
            mem_wdata = '{present: 1'b0, weight: cur.weight};
         end
         S_REBUILD: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = '{present: rb_present, weight: base_weight_ff};
         end
         S_REPLY: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: mem_we = 1'b0;
      endcase
   end

   // ---- datapath ----
   always_comb begin
      op_in         = op_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      wt_in         = wt_ff;
      row_in        = row_ff;
      sweep_in      = sweep_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_msrc_in   = res_msrc_ff;
      res_mw_in     = res_mw_ff;
      case (state_ff)
         S_CLEAR: begin
            sweep_in = sweep_ff + CELL_W'(1);
         end
         S_IDLE: begin
            if (req_accept) begin
               op_in         = req_act;
               src_in        = req_source;
               dst_in        = req_destination;
               wt_in         = req_weight;
               row_in        = '0;
               sweep_in      = '0;
               res_status_in = range_fail ? STAT_RANGE : STAT_DONE;
               res_found_in  = 1'b0;
               res_msrc_in   = '0;
               res_mw_in     = '0;
               if (req_act == ACT_REBUILD) count_in = '0;
            end
         end
         S_ACCESS: begin
            res_found_in = cur.present;
            case (op_ff)
               ACT_CONNECT_MIN, ACT_CONNECT_DEFAULT: begin
                  if (!cur.present) count_in = count_ff + COUNT_W'(1);
               end
               ACT_DISCONNECT: begin
                  if (cur.present) count_in = count_ff - COUNT_W'(1);
                  else res_status_in = STAT_MISSING;
               end
               ACT_SET, ACT_SET_DEFAULT: begin
                  if (!cur.present) res_status_in = STAT_MISSING;
               end
               ACT_QUERY: begin
                  if (cur.present) res_mw_in = cur.weight;
                  else res_status_in = STAT_MISSING;
               end
               default: res_found_in = cur.present;
            endcase
         end
         S_SCAN: begin
            row_in = row_ff + VERTEX_W'(1);
            if (cur.present) begin
               res_found_in = 1'b1;
               if (op_ff == ACT_MIN_INCOMING) begin
                  // strict compare keeps the lowest source on a tie
                  if (!res_found_ff || scan_lower) begin
                     res_msrc_in = row_ff;
                     res_mw_in   = cur.weight;
                  end
               end else begin
                  count_in = count_ff - COUNT_W'(1);
               end
            end
            if (row_last && op_ff == ACT_MIN_INCOMING && !res_found_ff && !cur.present) begin
               res_status_in = STAT_MISSING;
            end
         end
         S_REBUILD: begin
            sweep_in = sweep_ff + CELL_W'(1);
            if (rb_present) count_in = count_ff + COUNT_W'(1);
         end
         default: row_in = row_ff;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---- registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         sweep_ff        <= '0;
         count_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
         vertex_count_ff <= MAX_N;
         base_weight_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_type'(csr_index))
               CSR_VERTEX_COUNT:   vertex_count_ff <= csr_data[VCOUNT_W-1:0];
               CSR_DEFAULT_WEIGHT: base_weight_ff  <= csr_data[WEIGHT_W-1:0];
               default:            vertex_count_ff <= vertex_count_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      wt_ff         <= wt_in;
      row_ff        <= row_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_msrc_ff   <= res_msrc_in;
      res_mw_ff     <= res_mw_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_found_ff  <= res_found_ff;
         rsp_msrc_ff   <= res_msrc_ff;
         rsp_mw_ff     <= res_mw_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_min_source = rsp_msrc_ff;
   assign rsp_min_weight = rsp_mw_ff;
   assign rsp_edge_count = rsp_count_ff;

   // ---- assertions ----
   `ASSERT_IMPLIES(a_write_state, mem_we, (state_ff != S_IDLE && state_ff != S_REPLY), "RAM written outside a working state")
   `ASSERT_IMPLIES(a_scan_column, (mem_we && state_ff == S_SCAN), (mem_waddr[VERTEX_W-1:0] == dst_ff), "column scan wrote outside its column")
   `ASSERT_NEXT(a_reply_loads, (state_ff == S_REPLY && (!rsp_valid_ff || rsp_ready)), (rsp_valid_ff && state_ff == S_IDLE), "result not delivered to the response register")

endmodule

[tb/tb_weighted_edge_table.sv]
module tb_weighted_edge_table;
   timeunit 1ns;
   timeprecision 1ps;

   import wet_pkg::*;

   localparam logic [3:0]  ACT_RESERVED_LO = 4'd9;
   localparam logic [3:0]  ACT_RESERVED_HI = 4'd15;
   localparam int unsigned CYCLE_LIMIT     = 400_000;
   localparam int          HOLD_OFF_CYCLES = 400;

   typedef struct {
      status_type            status;
      logic                  found;
      logic [VERTEX_W-1:0]   min_source;
      logic [WEIGHT_W-1:0]   min_weight;
      logic [COUNT_W-1:0]    edge_count;
   } edge_result_type;

   logic                       clock           = 1'b0;
   logic                       reset           = 1'b1;
   logic                       req_valid       = 1'b0;
   logic                       req_ready;
   logic [3:0]                 req_action      = '0;
   logic [VERTEX_W-1:0]        req_source      = '0;
   logic [VERTEX_W-1:0]        req_destination = '0;
   logic signed [WEIGHT_W-1:0] req_weight      = '0;
   logic                       rsp_valid;
   logic                       rsp_ready       = 1'b0;
   logic [1:0]                 rsp_status;
   logic                       rsp_found;
   logic [VERTEX_W-1:0]        rsp_min_source;
   logic signed [WEIGHT_W-1:0] rsp_min_weight;
   logic [COUNT_W-1:0]         rsp_edge_count;
   logic                       csr_valid       = 1'b0;
   logic                       csr_ready;
   logic                       csr_index       = CSR_VERTEX_COUNT;
   logic [CSR_DATA_W-1:0]      csr_data        = '0;

   // shadow copy of the edge store and its settings
   logic [WEIGHT_W-1:0] link_weight [CELLS];
   bit                  link_present [CELLS];
   bit [COUNT_W-1:0]    link_total   = '0;
   bit [VCOUNT_W-1:0]   cfg_vertices = 6'd32;
   logic [WEIGHT_W-1:0] cfg_default  = '0;

   edge_result_type answers_due [$];
   int           mismatches  = 0;
   int unsigned  cycle_count = 0;
   bit           gapless     = 1'b0;
   bit           rsp_hold    = 1'b0;
   int           rsp_wait    = 0;

   weighted_edge_table i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_weighted_edge_table failed");
         $finish;
      end
   end

   function automatic int vertices_in_use();
      return (cfg_vertices < MAX_VERTICES) ? int'(cfg_vertices) : MAX_VERTICES;
   endfunction

   function automatic int draw_gap();
      if (gapless)
         return 0;
      return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
   endfunction

   function automatic edge_result_type apply_action(logic [3:0] act, logic [VERTEX_W-1:0] src,
         logic [VERTEX_W-1:0] dst, logic [WEIGHT_W-1:0] w);
      edge_result_type r;
      int           n;
      int           slot;
      r.status     = STAT_DONE;
      r.found      = 1'b0;
      r.min_source = '0;
      r.min_weight = '0;
      n            = vertices_in_use();
      slot         = src * MAX_VERTICES + dst;
      if (act == ACT_REBUILD) begin
         link_total = '0;
         for (int c = 0; c < CELLS; c++)
            link_present[c] = 1'b0;
         for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
               if (i != j) begin
                  link_present[i * MAX_VERTICES + j] = 1'b1;
                  link_weight[i * MAX_VERTICES + j]  = cfg_default;
                  link_total++;
               end
      end else if (act >= ACT_CONNECT_MIN && act <= ACT_QUERY) begin
         if (src >= n || dst >= n) begin
            r.status = STAT_RANGE;
         end else begin
            r.found = link_present[slot];
            case (act)
               ACT_CONNECT_MIN, ACT_CONNECT_DEFAULT: begin
                  if (!r.found) begin
                     link_present[slot] = 1'b1;
                     link_weight[slot]  = (act == ACT_CONNECT_MIN) ? w : cfg_default;
                     link_total++;
                  end else if (act == ACT_CONNECT_MIN &&
                               $signed(w) < $signed(link_weight[slot])) begin
                     link_weight[slot] = w;
                  end
               end
               ACT_DISCONNECT: begin
                  if (!r.found) begin
                     r.status = STAT_MISSING;
                  end else begin
                     link_present[slot] = 1'b0;
                     link_total--;
                  end
               end
               ACT_SET, ACT_SET_DEFAULT: begin
                  if (!r.found)
                     r.status = STAT_MISSING;
                  else
                     link_weight[slot] = (act == ACT_SET) ? w : cfg_default;
               end
               default: begin
                  if (!r.found)
                     r.status = STAT_MISSING;
                  else
                     r.min_weight = link_weight[slot];
               end
            endcase
         end
      end else if (act == ACT_MIN_INCOMING || act == ACT_REMOVE_INCOMING) begin
         if (dst >= n) begin
            r.status = STAT_RANGE;
         end else begin
            // walk every stored source, in use or not; strict compare keeps the lowest
            for (int i = 0; i < MAX_VERTICES; i++) begin
               slot = i * MAX_VERTICES + dst;
               if (link_present[slot]) begin
                  if (act == ACT_MIN_INCOMING) begin
                     if (!r.found || $signed(link_weight[slot]) < $signed(r.min_weight)) begin
                        r.min_weight = link_weight[slot];
                        r.min_source = VERTEX_W'(i);
                     end
                  end else begin
                     link_present[slot] = 1'b0;
                     link_total--;
                  end
                  r.found = 1'b1;
               end
            end
            if (act == ACT_MIN_INCOMING && !r.found)
               r.status = STAT_MISSING;
         end
      end
      r.edge_count = link_total;
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
      end
   endtask

   // result side: compare each transaction, then draw the next pause
   always @(posedge clock) begin
      edge_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result arrived with nothing outstanding", $realtime);
            end else begin
               want = answers_due.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("found", want.found, rsp_found);
               check_field("min_source", want.min_source, rsp_min_source);
               check_field("min_weight", want.min_weight, rsp_min_weight);
               check_field("edge_count", want.edge_count, rsp_edge_count);
            end
            rsp_wait = draw_gap();
         end else if (rsp_wait != 0) begin
            rsp_wait--;
         end
         rsp_ready <= (rsp_wait == 0) && !rsp_hold;
      end
   end

   // valid stays high across back-to-back transactions; drop it only before a pause
   task automatic send_item(logic [3:0] act, logic [VERTEX_W-1:0] src,
         logic [VERTEX_W-1:0] dst, logic [WEIGHT_W-1:0] w);
      int gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_source      <= src;
      req_destination <= dst;
      req_weight      <= w;
      do @(posedge clock); while (!req_ready);
      answers_due.insert(answers_due.size(), apply_action(act, src, dst, w));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (answers_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_config(logic [VCOUNT_W-1:0] vc, logic [WEIGHT_W-1:0] dw);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= CSR_VERTEX_COUNT;
      csr_data  <= {26'($urandom), vc};
      do @(posedge clock); while (!csr_ready);
      cfg_vertices = vc;
      csr_index <= CSR_DEFAULT_WEIGHT;
      csr_data  <= dw;
      do @(posedge clock); while (!csr_ready);
      cfg_default = dw;
      csr_valid <= 1'b0;
   endtask

   function automatic logic [VERTEX_W-1:0] pick_vertex(int n);
      if (n == 0 || $urandom_range(0, 9) == 0)
         return VERTEX_W'($urandom_range(0, MAX_VERTICES - 1));
      return VERTEX_W'($urandom_range(0, n - 1));
   endfunction

   task automatic random_item();
      int                  n;
      int                  pick;
      logic [3:0]          act;
      logic [WEIGHT_W-1:0] w;
      n    = vertices_in_use();
      pick = $urandom_range(0, 199);
      if (pick < 3)
         act = ACT_REBUILD;
      else if (pick < 7)
         act = 4'($urandom_range(ACT_RESERVED_LO, ACT_RESERVED_HI));
      else if (pick < 70)
         act = $urandom_range(0, 1) ? ACT_CONNECT_MIN : ACT_CONNECT_DEFAULT;
      else
         act = 4'($urandom_range(ACT_DISCONNECT, ACT_REMOVE_INCOMING));
      case ($urandom_range(0, 7))
         0:       w = 32'h8000_0000;
         1:       w = 32'h7fff_ffff;
         2, 3:    w = {16'($urandom_range(0, 4) - 2), 16'h0000};  // narrow set, for ties
         default: w = $urandom;
      endcase
      send_item(act, pick_vertex(n), pick_vertex(n), w);
   endtask

   task automatic test_edge_actions();
      send_item(ACT_QUERY, 0, 1, $urandom);
      send_item(ACT_CONNECT_MIN, 0, 1, 32'h7fff_ffff);
      send_item(ACT_CONNECT_MIN, 0, 1, 32'h7fff_ffff);
      send_item(ACT_CONNECT_MIN, 0, 1, 32'h8000_0000);
      send_item(ACT_QUERY, 0, 1, $urandom);
      send_item(ACT_CONNECT_DEFAULT, 31, 31, $urandom);
      send_item(ACT_CONNECT_DEFAULT, 31, 31, $urandom);
      send_item(ACT_SET, 31, 31, 32'hffff_ffff);
      send_item(ACT_SET, 5, 6, $urandom);
      send_item(ACT_SET_DEFAULT, 31, 31, $urandom);
      send_item(ACT_SET_DEFAULT, 5, 6, $urandom);
      send_item(ACT_CONNECT_MIN, 2, 1, 32'h8000_0000);
      send_item(ACT_CONNECT_MIN, 30, 1, 32'h8000_0000);
      send_item(ACT_MIN_INCOMING, 0, 1, $urandom);
      send_item(ACT_MIN_INCOMING, 0, 7, $urandom);
      send_item(ACT_REMOVE_INCOMING, 0, 1, $urandom);
      send_item(ACT_REMOVE_INCOMING, 0, 1, $urandom);
      send_item(ACT_DISCONNECT, 31, 31, $urandom);
      send_item(ACT_DISCONNECT, 31, 31, $urandom);
      send_item(ACT_RESERVED_LO, 3, 4, $urandom);
      send_item(ACT_RESERVED_HI, 31, 31, $urandom);
      send_item(ACT_REBUILD, 0, 0, $urandom);
      send_item(ACT_QUERY, 4, 4, $urandom);
      send_item(ACT_MIN_INCOMING, 0, 31, $urandom);
   endtask

   task automatic test_out_of_range();
      send_item(ACT_SET, 20, 1, 32'h8000_0000);
      set_config(6'd2, 32'h0001_0000);
      send_item(ACT_CONNECT_MIN, 2, 0, $urandom);
      send_item(ACT_QUERY, 0, 2, $urandom);
      send_item(ACT_DISCONNECT, 31, 0, $urandom);
      send_item(ACT_SET, 1, 5, $urandom);
      send_item(ACT_MIN_INCOMING, 0, 2, $urandom);
      send_item(ACT_REMOVE_INCOMING, 0, 31, $urandom);
      // sources beyond the vertex count still take part in the column walk
      send_item(ACT_MIN_INCOMING, 0, 1, $urandom);
      send_item(ACT_REMOVE_INCOMING, 0, 1, $urandom);
      send_item(ACT_REBUILD, 0, 0, $urandom);
      send_item(ACT_CONNECT_DEFAULT, 0, 0, $urandom);
      send_item(ACT_QUERY, 0, 0, $urandom);
   endtask

   // full table plus every self loop takes the counter past its top
   task automatic test_count_wrap();
      set_config(6'd32, $urandom);
      send_item(ACT_REBUILD, 0, 0, $urandom);
      for (int v = 0; v < MAX_VERTICES; v++)
         send_item($urandom_range(0, 1) ? ACT_CONNECT_MIN : ACT_CONNECT_DEFAULT,
                   VERTEX_W'(v), VERTEX_W'(v), $urandom);
      send_item(ACT_DISCONNECT, 0, 0, $urandom);
      send_item(ACT_MIN_INCOMING, 0, 5, $urandom);
   endtask

   task automatic test_backpressure();
      gapless <= 1'b1;
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      repeat (30) random_item();
      gapless <= 1'b0;
   endtask

   task automatic test_random_settings();
      int items;
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: set_config(6'd32, $urandom);
            1: set_config(6'd2, 32'h7fff_ffff);
            2: set_config(6'd63, 32'h8000_0000);
            3: set_config(VCOUNT_W'($urandom_range(3, 31)), $urandom);
            4: set_config(6'd1, $urandom);
            5: set_config(6'd0, $urandom);
            default: set_config(VCOUNT_W'($urandom_range(2, 32)), '0);
         endcase
         gapless <= ($urandom_range(0, 3) == 0);
         items = (phase == 4 || phase == 5) ? 20 : 80;
         if ($urandom_range(0, 1))
            send_item(ACT_REBUILD, 0, 0, $urandom);
         repeat (items) random_item();
      end
      gapless <= 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_edge_actions();
      test_out_of_range();
      test_count_wrap();
      test_backpressure();
      test_random_settings();
      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("tb_weighted_edge_table passed");
      else
         $display("tb_weighted_edge_table failed");
      $finish;
   end

endmodule

[sim.f]
+incdir+design
design/wet_pkg.sv
design/wet_ram.sv
design/weighted_edge_table.sv
tb/tb_weighted_edge_table.sv
